[design/indexed_list_store_core_macros.svh]
// assertion macros shared by the indexed list store design
`ifndef INDEXED_LIST_STORE_CORE_MACROS_SVH
`define INDEXED_LIST_STORE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define ILS_ASSERT_NOW(label, a_clk, a_rst_n, ante, conseq, msg) \
	label: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (conseq)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ILS_ASSERT_NEXT(label, a_clk, a_rst_n, ante, conseq, msg) \
	label: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (conseq)) \
		else $error(msg);

`endif

[design/ils_pkg.sv]
// shared types and codes of the indexed list store
package ils_pkg;

	localparam int POS_W = 5;
	localparam int CNT_OUT_W = 5;

	// operation codes
	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_REMOVE = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [31:0]      value_in;
		logic [POS_W-1:0] position;
	} in_item_t;

	typedef struct packed {
		logic [31:0]          value_out;
		logic [CNT_OUT_W-1:0] entry_count;
		logic [1:0]           status;
	} out_item_t;

	// finished result handed from the sequencer to the output stage
	typedef struct packed {
		logic      valid;
		out_item_t item;
	} res_hs_t;

endpackage

[design/ils_mem.sv]
// entry memory: one write port, one read port with registered data
module ils_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/ils_ctrl.sv]
// operation sequencer: checks, entry shifting and result assembly
module ils_ctrl #(
	parameter int DEPTH = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  ils_pkg::in_item_t        in_data,
	output ils_pkg::res_hs_t         res,
	input  logic                     res_take,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output logic [ELEM_WIDTH-1:0]    mem_wdata,
	output logic                     mem_re,
	output logic [$clog2(DEPTH)-1:0] mem_raddr,
	input  logic [ELEM_WIDTH-1:0]    mem_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_READ   = 6'b000010,
		S_RDWAIT = 6'b000100,
		S_SHIFT  = 6'b001000,
		S_FINAL  = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [1:0]            kind_q;
	logic [ELEM_WIDTH-1:0] val_q;
	logic [AW-1:0]         pos_q;
	logic [CW-1:0]         left_q;
	logic [AW-1:0]         raddr_q;
	logic                  mv_s1;
	logic [AW-1:0]         mv_addr_s1;
	ils_pkg::out_item_t    res_q;

	logic          accept;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic          full;
	logic          empty;
	logic [1:0]    stat;
	logic          grows;
	logic [CW-1:0] cnt_next;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign pos_x = XW'(in_data.position);
	assign cnt_x = XW'(count_q);
	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign grows = (kind_q == ils_pkg::KIND_APPEND) || (kind_q == ils_pkg::KIND_INSERT);
	assign cnt_next = grows ? count_q + CW'(1) : count_q - CW'(1);

	// bounds and capacity checks for the incoming item
	always_comb begin
		stat = ils_pkg::STAT_OK;
		case (in_data.kind)
			ils_pkg::KIND_APPEND: begin
				if (full) stat = ils_pkg::STAT_FULL;
			end
			ils_pkg::KIND_INSERT: begin
				if (full) stat = ils_pkg::STAT_FULL;
				else if (pos_x > cnt_x) stat = ils_pkg::STAT_RANGE;
			end
			default: begin
				if (empty) stat = ils_pkg::STAT_EMPTY;
				else if (pos_x >= cnt_x) stat = ils_pkg::STAT_RANGE;
			end
		endcase
	end

	// memory port drive: shift write-back has the write port, else the final write
	always_comb begin
		mem_we = mv_s1 || ((state_q == S_FINAL) && grows);
		mem_waddr = mv_s1 ? mv_addr_s1 : pos_q;
		mem_wdata = mv_s1 ? mem_rdata : val_q;
		mem_re = 1'b0;
		mem_raddr = raddr_q;
		case (state_q)
			S_READ: begin
				mem_re = 1'b1;
				mem_raddr = pos_q;
			end
			S_SHIFT: begin
				mem_re = (left_q != '0);
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	assign res.valid = (state_q == S_DONE);
	assign res.item = res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			mv_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (stat != ils_pkg::STAT_OK) state_q <= S_DONE;
						else if (in_data.kind == ils_pkg::KIND_APPEND) state_q <= S_FINAL;
						else if (in_data.kind == ils_pkg::KIND_READ) state_q <= S_READ;
						else state_q <= S_SHIFT;
					end
				end
				S_READ: begin
					state_q <= S_RDWAIT;
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_SHIFT: begin
					mv_s1 <= (left_q != '0);
					if (left_q == '0) state_q <= S_FINAL;
				end
				S_FINAL: begin
					count_q <= cnt_next;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operands, shift pointers and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q <= in_data.kind;
					val_q <= ELEM_WIDTH'(in_data.value_in);
					res_q.value_out <= '0;
					res_q.status <= stat;
					res_q.entry_count <= ils_pkg::CNT_OUT_W'(count_q);
					pos_q <= (in_data.kind == ils_pkg::KIND_APPEND) ? AW'(count_q) : AW'(pos_x);
					if (in_data.kind == ils_pkg::KIND_INSERT) begin
						left_q <= CW'(cnt_x - pos_x);
						raddr_q <= AW'(cnt_x - XW'(1));
					end else begin
						left_q <= CW'(cnt_x - pos_x - XW'(1));
						raddr_q <= AW'(pos_x + XW'(1));
					end
				end
			end
			S_RDWAIT: begin
				res_q.value_out <= 32'(mem_rdata);
			end
			S_SHIFT: begin
				// insert walks down and moves up, remove walks up and moves down
				if (left_q != '0) begin
					left_q <= left_q - CW'(1);
					if (kind_q == ils_pkg::KIND_INSERT) begin
						raddr_q <= raddr_q - AW'(1);
						mv_addr_s1 <= raddr_q + AW'(1);
					end else begin
						raddr_q <= raddr_q + AW'(1);
						mv_addr_s1 <= raddr_q - AW'(1);
					end
				end
			end
			S_FINAL: begin
				res_q.entry_count <= ils_pkg::CNT_OUT_W'(cnt_next);
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule

[design/indexed_list_store_core.sv]
// Indexed list store: append, insert, read and remove on a list held in one memory.
// A rejected item goes straight to the result; append makes one write and read one read;
// insert or remove first moves n entries (n at most DEPTH - 1), then insert writes the new value.
// One item at a time: a new item is taken only once the last result has gone to the output
// register; insert and remove spend one memory read and one write per moved entry.
// Reset clears the entry count and handshake state; the entry memory is not cleared.
`include "indexed_list_store_core_macros.svh"

module indexed_list_store_core #(
	parameter int DEPTH = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ils_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ils_pkg::out_item_t out_data
);

	localparam int AW = $clog2(DEPTH);

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [ELEM_WIDTH-1:0] mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [ELEM_WIDTH-1:0] mem_rdata;
	ils_pkg::res_hs_t      res;
	logic                  res_take;
	logic                  out_valid_q;
	ils_pkg::out_item_t    out_data_q;

	ils_ctrl #(
		.DEPTH(DEPTH),
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.res(res),
		.res_take(res_take),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ils_mem #(
		.DEPTH(DEPTH),
		.WIDTH(ELEM_WIDTH)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register: takes a result when empty or being drained
	assign res_take = res.valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_data_q <= res.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// the sequencer is busy in the cycle after it accepts an item
	`ILS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "input taken twice in a row")

	// the sequencer never offers a result while it can take a new item
	`ILS_ASSERT_NOW(a_result_not_idle, clk, arst_n, res.valid, !in_ready, "result offered while idle")

	// an empty-list rejection reports zero entries
	`ILS_ASSERT_NOW(a_empty_count, clk, arst_n, res_take && (res.item.status == ils_pkg::STAT_EMPTY), res.item.entry_count == '0, "empty status with nonzero count")

endmodule
